// ===== rtl/bbd_pkg.sv =====
// shared constants and types for the box binning downsampler
`default_nettype none

package bbd_pkg;

  // field widths
  localparam int SAMPLE_W  = 32;
  localparam int SUM_W     = 40;
  localparam int COORD_W   = 10;
  localparam int FACTOR_W  = 5;
  localparam int SIDE_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE   = 2'd1;

  // position flags of one subpixel inside its block and frame
  typedef struct packed {
    logic first;       // top-left subpixel of a block
    logic last;        // bottom-right subpixel of a block
    logic frame_last;  // block is the last pixel of the frame
  } blk_flags_t;

endpackage

`default_nettype wire

// ===== rtl/bbd_coord.sv =====
// configuration registers and subpixel position counters
`default_nettype none

module bbd_coord
  import bbd_pkg::*;
#(
  parameter int MAX_SIDE   = 1024,
  parameter int MAX_FACTOR = 16,
  parameter int XW         = 10,
  parameter int FW         = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 step,
  output logic      [XW-1:0]        ox,
  output logic      [XW-1:0]        oy,
  output blk_flags_t                flags
);

  logic [FACTOR_W-1:0] factor_r;
  logic [SIDE_W-1:0]   side_r;
  logic [FW-1:0]       dx_r;
  logic [FW-1:0]       dy_r;
  logic [XW-1:0]       ox_r;
  logic [XW-1:0]       oy_r;

  logic [6:0]    f_wide;
  logic [6:0]    f_clamp;
  logic [6:0]    fm1_wide;
  logic [FW-1:0] fm1;
  logic [12:0]   s_wide;
  logic [12:0]   s_clamp;
  logic [12:0]   sm1_wide;
  logic [XW-1:0] sm1;
  logic          restart;

  // clamp factor and side to their usable ranges
  always_comb begin
    f_wide  = {2'b00, factor_r};
    f_clamp = f_wide;
    if (f_wide == 7'd0) begin
      f_clamp = 7'd1;
    end else if (f_wide > 7'(MAX_FACTOR)) begin
      f_clamp = 7'(MAX_FACTOR);
    end
    fm1_wide = f_clamp - 7'd1;
    fm1      = fm1_wide[FW-1:0];

    s_wide  = {2'b00, side_r};
    s_clamp = s_wide;
    if (s_wide == 13'd0) begin
      s_clamp = 13'd1;
    end else if (s_wide > 13'(MAX_SIDE)) begin
      s_clamp = 13'(MAX_SIDE);
    end
    sm1_wide = s_clamp - 13'd1;
    sm1      = sm1_wide[XW-1:0];
  end

  // any write to a known register restarts the frame
  assign restart = cfg_we && ((cfg_index == CFG_FACTOR) || (cfg_index == CFG_SIDE));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_W'(1);
      side_r   <= SIDE_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FACTOR: factor_r <= cfg_data[FACTOR_W-1:0];
        CFG_SIDE:   side_r   <= cfg_data[SIDE_W-1:0];
        default:    ;
      endcase
    end
  end

  // nested counters: subcolumn, column, subrow, row
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      dx_r <= '0;
      dy_r <= '0;
      ox_r <= '0;
      oy_r <= '0;
    end else if (step) begin
      if (dx_r == fm1) begin
        dx_r <= '0;
        if (ox_r == sm1) begin
          ox_r <= '0;
          if (dy_r == fm1) begin
            dy_r <= '0;
            if (oy_r == sm1) begin
              oy_r <= '0;
            end else begin
              oy_r <= oy_r + XW'(1);
            end
          end else begin
            dy_r <= dy_r + FW'(1);
          end
        end else begin
          ox_r <= ox_r + XW'(1);
        end
      end else begin
        dx_r <= dx_r + FW'(1);
      end
    end
  end

  // position of the current subpixel
  assign ox               = ox_r;
  assign oy               = oy_r;
  assign flags.first      = (dx_r == '0) && (dy_r == '0);
  assign flags.last       = (dx_r == fm1) && (dy_r == fm1);
  assign flags.frame_last = (ox_r == sm1) && (oy_r == sm1);

endmodule

`default_nettype wire

// ===== rtl/box_binning_downsampler.sv =====
// top level of the box binning downsampler
`default_nettype none

// Sums each factor-by-factor block of a raster-order subpixel stream into one
// output pixel, emitted with its column, row and a frame-last mark on the
// item that brings the block's bottom-right subpixel. Sustained rate is one
// subpixel item per clock; an item is read from the row store at acceptance
// and its updated partial sum is written back by the write-back stage, with
// the sum forwarded when the next item hits the same column. A result enters
// the output register as its last subpixel leaves the write-back stage; the
// input stalls only while a finished pixel waits in the output register and
// the next one is ready. The row store holds one 40-bit partial sum per output
// column and needs no clearing: a block's first subpixel overwrites its entry.
// A factor or side register write restarts the frame at the top-left subpixel.
module box_binning_downsampler
  import bbd_pkg::*;
#(
  parameter int MAX_SIDE   = 1024,
  parameter int MAX_FACTOR = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SAMPLE_W-1:0]  in_sample,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [SUM_W-1:0]     out_pixel_value,
  output logic      [COORD_W-1:0]   out_pixel_x,
  output logic      [COORD_W-1:0]   out_pixel_y,
  output logic                      out_frame_last,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int XW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  logic [XW-1:0] cur_ox;
  logic [XW-1:0] cur_oy;
  blk_flags_t    cur_flags;
  logic          in_acc;

  // row store of partial block sums
  logic [SUM_W-1:0] row_mem [MAX_SIDE];
  logic [SUM_W-1:0] rd_data_r;

  // write-back stage
  logic                s1_valid_r;
  logic [SAMPLE_W-1:0] s1_sample_r;
  blk_flags_t          s1_flags_r;
  logic [XW-1:0]       s1_ox_r;
  logic [XW-1:0]       s1_oy_r;
  logic                fwd_hit_r;
  logic [SUM_W-1:0]    fwd_data_r;

  logic [SUM_W-1:0] s1_operand;
  logic [SUM_W-1:0] s1_sext;
  logic [SUM_W-1:0] s1_acc;
  logic             out_free;
  logic             s1_adv;

  logic                 out_valid_r;
  logic [SUM_W-1:0]     out_value_r;
  logic [XW-1:0]        out_ox_r;
  logic [XW-1:0]        out_oy_r;
  logic                 out_last_r;
  logic [XW+COORD_W-1:0] ox_ext;
  logic [XW+COORD_W-1:0] oy_ext;

  // position counters and configuration
  bbd_coord #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_FACTOR (MAX_FACTOR),
    .XW         (XW),
    .FW         (FW)
  ) u_coord (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_acc),
    .ox        (cur_ox),
    .oy        (cur_oy),
    .flags     (cur_flags)
  );

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_flags_r.last || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // accumulate with forwarding of the write made at the read edge
  always_comb begin
    s1_sext    = {{(SUM_W-SAMPLE_W){s1_sample_r[SAMPLE_W-1]}}, s1_sample_r};
    s1_operand = fwd_hit_r ? fwd_data_r : rd_data_r;
    s1_acc     = s1_flags_r.first ? s1_sext : s1_operand + s1_sext;
  end

  // row store write-back and registered read
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      row_mem[s1_ox_r] <= s1_acc;
    end
    if (in_acc) begin
      rd_data_r <= row_mem[cur_ox];
    end
  end

  // stage payload and forwarding data
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample;
      s1_flags_r  <= cur_flags;
      s1_ox_r     <= cur_ox;
      s1_oy_r     <= cur_oy;
      fwd_data_r  <= s1_acc;
    end
  end

  // stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_adv && (s1_ox_r == cur_ox);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_flags_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags_r.last) begin
      out_value_r <= s1_acc;
      out_ox_r    <= s1_ox_r;
      out_oy_r    <= s1_oy_r;
      out_last_r  <= s1_flags_r.frame_last;
    end
  end

  // coordinates fitted to the port width
  assign ox_ext = {{COORD_W{1'b0}}, out_ox_r};
  assign oy_ext = {{COORD_W{1'b0}}, out_oy_r};

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_value_r;
  assign out_pixel_x     = ox_ext[COORD_W-1:0];
  assign out_pixel_y     = oy_ext[COORD_W-1:0];
  assign out_frame_last  = out_last_r;

endmodule

`default_nettype wire
